// ===== rtl/ippf_pkg.sv =====
package ippf_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PREFIX = 2'd1;
  localparam logic [1:0] ST_FULL       = 2'd2;

  // Request codes
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Longest legal prefix per family
  localparam logic [7:0] PLEN_V4_MAX = 8'd32;
  localparam logic [7:0] PLEN_V6_MAX = 8'd128;

  // One stored rule (address already masked to its prefix)
  typedef struct packed {
    logic        sock_type;
    logic        is_ipv6;
    logic [7:0]  prefix_len;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
  } rule_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_item;
    logic add_commit;
    logic scan_clear;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_check;
    logic scan_done;
  } stat_t;

  // 128-bit prefix mask {hi, lo}; IPv4 mask sits in bits 31:0.
  // Prefix is assumed in range for its family.
  function automatic logic [127:0] make_mask(input logic v6, input logic [7:0] plen);
    logic [127:0] m;
    logic [31:0]  m4;
    m  = ~({128{1'b1}} >> plen);
    m4 = ~(32'hFFFF_FFFF >> plen);
    if (v6) begin
      return m;
    end else begin
      return {96'd0, m4};
    end
  endfunction

endpackage

// ===== rtl/ippf_if.sv =====
// Request channel
interface ippf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        sock_type;
  logic        is_ipv6;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [7:0]  prefix_len;
  logic [15:0] port;

  modport source (output valid, req_type, sock_type, is_ipv6, addr_hi, addr_lo,
                  prefix_len, port, input ready);
  modport sink (input valid, req_type, sock_type, is_ipv6, addr_hi, addr_lo,
                prefix_len, port, output ready);
endinterface

// Result channel
interface ippf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       matched;

  modport source (output valid, status, matched, input ready);
  modport sink (input valid, status, matched, output ready);
endinterface

// ===== rtl/ippf_ram.sv =====
module ippf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ippf_ctrl.sv =====
module ippf_ctrl import ippf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output slot is free when empty or being drained this cycle
  logic slot_free;
  assign slot_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_EXEC;
      S_EXEC: state_next = stat.is_check ? S_SCAN : S_DONE;
      S_SCAN: if (stat.scan_done) state_next = S_DONE;
      S_DONE: if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      S_EXEC: begin
        cmd.scan_clear = stat.is_check;
        cmd.add_commit = !stat.is_check;
      end
      S_SCAN: cmd.scan_step = 1'b1;
      S_DONE: cmd.load_out = slot_free;
      default: ;
    endcase
  end

  // Result register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/ippf_dp.sv =====
module ippf_dp import ippf_pkg::*; #(
  parameter int MAX_RULES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        req_type,
  input  logic        sock_type,
  input  logic        is_ipv6,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  prefix_len,
  input  logic [15:0] port,
  output logic [1:0]  status,
  output logic        matched
);

  localparam int CNT_W  = $clog2(MAX_RULES + 1);
  localparam int ADDR_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  // Latched request
  logic        it_check;
  logic        it_stype;
  logic        it_v6;
  logic [63:0] it_hi;
  logic [63:0] it_lo;
  logic [7:0]  it_plen;
  logic [15:0] it_port;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_check <= (req_type == REQ_CHECK);
      it_stype <= sock_type;
      it_v6    <= is_ipv6;
      it_hi    <= is_ipv6 ? addr_hi : 64'd0;
      it_lo    <= is_ipv6 ? addr_lo : {32'd0, addr_lo[31:0]};
      it_plen  <= prefix_len;
      it_port  <= port;
    end
  end

  // Add path: range check, fill check, masked rule
  logic [CNT_W-1:0] count;
  logic             bad_prefix;
  logic             full;
  logic             add_ok;
  logic [127:0]     add_mask;
  rule_t            wr_rule;

  assign bad_prefix = it_plen > (it_v6 ? PLEN_V6_MAX : PLEN_V4_MAX);
  assign full       = (count == CNT_W'(MAX_RULES));
  assign add_ok     = cmd.add_commit && !bad_prefix && !full;
  assign add_mask   = make_mask(it_v6, it_plen);

  always_comb begin
    wr_rule.sock_type  = it_stype;
    wr_rule.is_ipv6    = it_v6;
    wr_rule.prefix_len = it_plen;
    wr_rule.addr_hi    = it_hi & add_mask[127:64];
    wr_rule.addr_lo    = it_lo & add_mask[63:0];
    wr_rule.port       = it_port;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (add_ok) begin
      count <= count + CNT_W'(1);
    end
  end

  // Scan pointer: one rule read per cycle
  logic [CNT_W-1:0]   idx;
  logic               idx_live;
  logic               rd_en;
  logic               cmp_valid;
  logic [$bits(rule_t)-1:0] rd_bits;
  rule_t              rd_rule;

  assign idx_live = idx < count;
  assign rd_en    = cmd.scan_step && idx_live;
  assign rd_rule  = rule_t'(rd_bits);

  ippf_ram #(
    .WIDTH ($bits(rule_t)),
    .DEPTH (MAX_RULES)
  ) u_rules (
    .clk   (clk),
    .we    (add_ok),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wr_rule),
    .re    (rd_en),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_bits)
  );

  // Compare the rule read last cycle against the request
  logic [127:0] rd_mask;
  logic         hit;

  assign rd_mask = make_mask(rd_rule.is_ipv6, rd_rule.prefix_len);
  assign hit = (rd_rule.sock_type == it_stype) && (rd_rule.is_ipv6 == it_v6) &&
               ((rd_rule.port == 16'd0) || (rd_rule.port == it_port)) &&
               ((it_hi & rd_mask[127:64]) == rd_rule.addr_hi) &&
               ((it_lo & rd_mask[63:0]) == rd_rule.addr_lo);

  // Result accumulation
  logic       match;
  logic [1:0] res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan_clear) begin
      idx       <= '0;
      cmp_valid <= 1'b0;
    end else if (cmd.scan_step) begin
      if (idx_live) begin
        idx <= idx + CNT_W'(1);
      end
      cmp_valid <= idx_live;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      match      <= 1'b0;
      res_status <= ST_OK;
    end else if (cmd.add_commit) begin
      match      <= 1'b0;
      res_status <= bad_prefix ? ST_BAD_PREFIX : (full ? ST_FULL : ST_OK);
    end else if (cmd.scan_step && cmp_valid && hit) begin
      match <= 1'b1;
    end
  end

  assign stat.is_check  = it_check;
  assign stat.scan_done = !idx_live && !cmp_valid;

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status  <= res_status;
      matched <= match;
    end
  end

endmodule

// ===== rtl/ip_prefix_port_rule_filter_unit.sv =====
// IP prefix / port rule filter.
// in_ch carries requests: req_type 0 adds a rule (type, family, address,
// prefix_len, port), req_type 1 checks an address against the stored rules.
// out_ch returns one result per request: status (ok, bad prefix, table full)
// and matched (check only). Both channels transfer on valid && ready.
// An add is committed in the exec state, while a check sweeps the rule RAM
// one entry per cycle through its single read port. Either result is then
// loaded into the output register from the done state once that register is
// free; the next request is taken in the cycle after it is loaded.
// One request is processed at a time; in_ch.ready is high whenever the
// engine is idle, even while a finished result still waits in the output
// register. If out_ch is stalled, the next result holds in the engine until
// the output register drains.
// Reset (rst, synchronous) empties the rule table and the output register;
// the rule RAM itself is not cleared, only entries below the fill count are
// ever read.
module ip_prefix_port_rule_filter_unit import ippf_pkg::*; #(
  parameter int MAX_RULES = 64
) (
  input  logic   clk,
  input  logic   rst,
  ippf_in_if.sink  in_ch,
  ippf_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  ippf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ippf_dp #(
    .MAX_RULES (MAX_RULES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (in_ch.req_type),
    .sock_type  (in_ch.sock_type),
    .is_ipv6    (in_ch.is_ipv6),
    .addr_hi    (in_ch.addr_hi),
    .addr_lo    (in_ch.addr_lo),
    .prefix_len (in_ch.prefix_len),
    .port       (in_ch.port),
    .status     (out_ch.status),
    .matched    (out_ch.matched)
  );

endmodule

// ===== rtl/ippf_checker.sv =====
module ippf_checker import ippf_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       matched
);

  // A pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_BAD_PREFIX || status == ST_FULL))
    else $error("undefined status code");

  // A match is only reported with ok status
  a_match_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && matched |-> status == ST_OK)
    else $error("match reported with error status");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ip_prefix_port_rule_filter_unit ippf_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .matched   (out_ch.matched)
);
